@@ design/dlts_pkg.sv @@
// Shared types and codes for the delta-list task scheduler.
// No dependencies; dlts_engine, delta_list_task_scheduler and the testbench import this package.
package dlts_pkg;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_ADD_AUTO = 3'd1;
    localparam logic [2:0] ACT_ADD_ID   = 3'd2;
    localparam logic [2:0] ACT_DISPATCH = 3'd3;
    localparam logic [2:0] ACT_DELETE   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE_DUE  = 2'd3;

    localparam logic [7:0] RUNS_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
        logic [15:0] task_ident;
        logic [15:0] job_tag;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        ran;
        logic [15:0] run_tag;
        logic [15:0] run_ident;
        logic [4:0]  slot;
    } result_t;

    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] period;
        logic [7:0]  runs;
        logic [15:0] ident;
        logic [15:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

@@ design/dlts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/dlts_engine.sv @@
// Sequencer and datapath of the scheduler: scans, shifts and updates the table.
// Depends on dlts_pkg and dlts_ram.
module dlts_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dlts_pkg::item_t    item,
    input  logic               res_ready,
    output dlts_pkg::eng_stat_t stat,
    output dlts_pkg::result_t  res
);
    import dlts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_HEAD_CHK = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_MOVE_RD  = 8'b0001_0000,
        S_MOVE_WR  = 8'b0010_0000,
        S_PUT      = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    entry_t        ins_reg, ins_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   rem_delta_reg, rem_delta_next;
    logic [31:0]   old_delta_reg, old_delta_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   auto_reg, auto_next;
    logic          dir_up_reg, dir_up_next;
    logic          scan_del_reg, scan_del_next;
    logic          reins_reg, reins_next;
    result_t       res_reg, res_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    entry_t        e;
    logic [32:0]   sum33;
    logic [CW-1:0] src_ptr;
    logic          rm_start, rm_done, ins_start, shift_start;

    dlts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = entry_t'(rdata_raw);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ins_next       = ins_reg;
        acc_next       = acc_reg;
        rem_delta_next = rem_delta_reg;
        old_delta_next = old_delta_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        auto_next      = auto_reg;
        dir_up_next    = dir_up_reg;
        scan_del_next  = scan_del_reg;
        reins_next     = reins_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = rdata;
        raddr          = '0;
        e              = rdata;
        sum33          = '0;
        src_ptr        = dir_up_reg ? (ptr_reg - ONE_C) : (ptr_reg + ONE_C);
        rm_start       = 1'b0;
        rm_done        = 1'b0;
        ins_start      = 1'b0;
        shift_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = item.action;
                    res_next = '0;
                    ins_next = '{delta: item.delay_ticks, period: item.period_ticks,
                                 runs: 8'd0, ident: item.task_ident, tag: item.job_tag};
                    priority if (item.action == ACT_TICK || item.action == ACT_DISPATCH)
                    begin
                        if (count_reg == '0)
                        begin
                            if (item.action == ACT_DISPATCH)
                            begin
                                res_next.status = ST_NONE_DUE;
                            end
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_HEAD_CHK;
                        end
                    end
                    else if (item.action == ACT_ADD_AUTO || item.action == ACT_ADD_ID)
                    begin
                        if (item.action == ACT_ADD_AUTO)
                        begin
                            ins_next.ident = auto_reg;
                            auto_next      = auto_reg + 16'd1;
                        end
                        res_next.run_ident = ins_next.ident;
                        ins_start          = 1'b1;
                    end
                    else if (item.action == ACT_DELETE)
                    begin
                        ptr_next      = '0;
                        scan_del_next = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_HEAD_CHK:
            begin
                if (op_reg == ACT_TICK)
                begin
                    we    = 1'b1;
                    wdata = e;
                    if (e.delta != '0)
                    begin
                        wdata.delta = e.delta - 32'd1;
                    end
                    else if (e.runs != RUNS_MAX)
                    begin
                        wdata.runs = e.runs + 8'd1;
                    end
                    state_next = S_FIN;
                end
                else if (e.runs == '0)
                begin
                    res_next.status = ST_NONE_DUE;
                    state_next      = S_FIN;
                end
                else
                begin
                    res_next.ran       = 1'b1;
                    res_next.run_tag   = e.tag;
                    res_next.run_ident = e.ident;
                    ins_next = '{delta: e.period, period: e.period, runs: 8'd0,
                                 ident: e.ident, tag: e.tag};
                    reins_next     = (e.period != '0);
                    rem_delta_next = e.delta;
                    pos_next       = '0;
                    rm_start       = 1'b1;
                end
            end

            S_SCAN_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    raddr      = ptr_reg[AW-1:0];
                    state_next = S_SCAN_CHK;
                end
                else if (scan_del_reg)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_FIN;
                end
                else
                begin
                    pos_next    = ptr_reg;
                    shift_start = 1'b1;
                end
            end

            S_SCAN_CHK:
            begin
                sum33 = {1'b0, acc_reg} + {1'b0, e.delta};
                if (scan_del_reg)
                begin
                    if (e.ident == ins_reg.ident)
                    begin
                        pos_next           = ptr_reg;
                        rem_delta_next     = e.delta;
                        res_next.run_ident = ins_reg.ident;
                        reins_next         = 1'b0;
                        rm_start           = 1'b1;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + ONE_C;
                        state_next = S_SCAN_RD;
                    end
                end
                else if ({1'b0, ins_reg.delta} < sum33)
                begin
                    pos_next       = ptr_reg;
                    old_delta_next = e.delta;
                    shift_start    = 1'b1;
                end
                else
                begin
                    acc_next   = sum33[31:0];
                    ptr_next   = ptr_reg + ONE_C;
                    state_next = S_SCAN_RD;
                end
            end

            S_MOVE_RD:
            begin
                raddr      = src_ptr[AW-1:0];
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[AW-1:0];
                wdata = e;
                if (dir_up_reg)
                begin
                    // The entry pushed up now follows the new task.
                    if (src_ptr == pos_reg)
                    begin
                        wdata.delta = old_delta_reg - (ins_reg.delta - acc_reg);
                    end
                    ptr_next = src_ptr;
                    if (src_ptr > pos_reg)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    // The entry after the removed one takes over its delay.
                    if (ptr_reg == pos_reg)
                    begin
                        sum33 = {1'b0, e.delta} + {1'b0, rem_delta_reg};
                        wdata.delta = sum33[32] ? '1 : sum33[31:0];
                    end
                    ptr_next = src_ptr;
                    if ((src_ptr + ONE_C) < count_reg)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        rm_done = 1'b1;
                    end
                end
            end

            S_PUT:
            begin
                we          = 1'b1;
                waddr       = pos_reg[AW-1:0];
                wdata       = ins_reg;
                wdata.delta = ins_reg.delta - acc_reg;
                count_next  = count_reg + ONE_C;
                if (op_reg == ACT_ADD_AUTO || op_reg == ACT_ADD_ID)
                begin
                    res_next.slot = 5'(pos_reg);
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rm_start)
        begin
            ptr_next    = pos_next;
            dir_up_next = 1'b0;
            if ((pos_next + ONE_C) < count_reg)
            begin
                state_next = S_MOVE_RD;
            end
            else
            begin
                rm_done = 1'b1;
            end
        end

        if (rm_done)
        begin
            count_next = count_reg - ONE_C;
            if (reins_next)
            begin
                ins_start = 1'b1;
            end
            else
            begin
                state_next = S_FIN;
            end
        end

        if (ins_start)
        begin
            if (count_next >= DEPTH_C)
            begin
                res_next.status = ST_FULL;
                res_next.slot   = 5'(DEPTH_C);
                state_next      = S_FIN;
            end
            else
            begin
                ptr_next      = '0;
                acc_next      = '0;
                scan_del_next = 1'b0;
                state_next    = S_SCAN_RD;
            end
        end

        if (shift_start)
        begin
            ptr_next    = count_reg;
            dir_up_next = 1'b1;
            if (count_reg > pos_next)
            begin
                state_next = S_MOVE_RD;
            end
            else
            begin
                state_next = S_PUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            auto_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            auto_reg  <= auto_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ins_reg       <= ins_next;
        acc_reg       <= acc_next;
        rem_delta_reg <= rem_delta_next;
        old_delta_reg <= old_delta_next;
        ptr_reg       <= ptr_next;
        pos_reg       <= pos_next;
        dir_up_reg    <= dir_up_next;
        scan_del_reg  <= scan_del_next;
        reins_reg     <= reins_next;
        res_reg       <= res_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FIN);
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !we)
        else $error("table written while idle");

    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT |=> count_reg == $past(count_reg) + ONE_C)
        else $error("insert did not grow the table");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && !res_ready |=> state_reg == S_FIN && $stable(res_reg))
        else $error("result lost before hand-off");
endmodule

@@ design/delta_list_task_scheduler.sv @@
// Delta-list task scheduler. One item is taken at a time; the input stalls until its
// result is registered. A dispatch removes the head with a shift down, then rescans and
// reinserts the task if it is periodic. A stalled result beat keeps the input stalled.
// Reset clears the entry count and id counter; table contents are left as they are.
module delta_list_task_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dlts_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output dlts_pkg::result_t result
);
    import dlts_pkg::*;

    eng_stat_t stat;
    result_t   eng_res;
    logic      res_ready;
    logic      out_valid_reg, out_valid_next;
    result_t   out_reg, out_next;

    dlts_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (item_valid && !item_stall),
        .item      (item),
        .res_ready (res_ready),
        .stat      (stat),
        .res       (eng_res)
    );

    // The result register frees when empty or when its beat is taken.
    assign res_ready  = !out_valid_reg || !result_stall;
    assign item_stall = !stat.idle;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (stat.done && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = eng_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
endmodule

@@ tb/delta_list_task_scheduler_test.sv @@
// Self-checking testbench for the delta-list task scheduler.
// Depends on dlts_pkg and delta_list_task_scheduler; predicts each result in a local table model.
module delta_list_task_scheduler_test;
    import dlts_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    delta_list_task_scheduler #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    // Scheduler state as the testbench believes it to be.
    logic [31:0] sched_delta [DEPTH];
    logic [31:0] sched_period [DEPTH];
    logic [7:0]  sched_runs [DEPTH];
    logic [15:0] sched_ident [DEPTH];
    logic [15:0] sched_tag [DEPTH];
    int          sched_count;
    logic [15:0] next_auto_ident;

    result_t expected_results[$];
    int      error_count;
    int      beats_sent;
    int      beats_checked;
    int      dispatch_hits;
    int      full_hits;
    longint  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void copy_slot(int dst, int src);
        sched_delta[dst]  = sched_delta[src];
        sched_period[dst] = sched_period[src];
        sched_runs[dst]   = sched_runs[src];
        sched_ident[dst]  = sched_ident[src];
        sched_tag[dst]    = sched_tag[src];
    endfunction

    function automatic void drop_slot(int pos);
        logic [32:0] merged;
        if (pos + 1 < sched_count)
        begin
            merged = {1'b0, sched_delta[pos + 1]} + {1'b0, sched_delta[pos]};
            sched_delta[pos + 1] = merged[32] ? 32'hFFFF_FFFF : merged[31:0];
        end
        for (int i = pos; i + 1 < sched_count; i++)
            copy_slot(i, i + 1);
        sched_count--;
    endfunction

    function automatic int place_task(logic [31:0] delay, logic [31:0] period,
                                      logic [15:0] ident, logic [15:0] tag);
        int          pos;
        logic [33:0] acc;
        pos = 0;
        acc = '0;
        if (sched_count >= DEPTH)
            return DEPTH;
        while (pos < sched_count)
        begin
            if ({2'b0, delay} < acc + sched_delta[pos])
                break;
            acc += sched_delta[pos];
            pos++;
        end
        for (int j = sched_count; j > pos; j--)
            copy_slot(j, j - 1);
        sched_delta[pos]  = delay - acc[31:0];
        sched_period[pos] = period;
        sched_runs[pos]   = '0;
        sched_ident[pos]  = ident;
        sched_tag[pos]    = tag;
        if (pos < sched_count)
            sched_delta[pos + 1] -= sched_delta[pos];
        sched_count++;
        return pos;
    endfunction

    function automatic result_t predict_schedule(item_t it);
        result_t     r;
        logic [15:0] id;
        logic [31:0] per;
        int          pos;
        r = '0;
        case (it.action)
            ACT_TICK:
                if (sched_count > 0)
                begin
                    if (sched_delta[0] > 0)
                        sched_delta[0]--;
                    else if (sched_runs[0] < RUNS_MAX)
                        sched_runs[0]++;
                end
            ACT_ADD_AUTO, ACT_ADD_ID:
            begin
                id = it.task_ident;
                if (it.action == ACT_ADD_AUTO)
                begin
                    id = next_auto_ident;
                    next_auto_ident++;
                end
                pos = place_task(it.delay_ticks, it.period_ticks, id, it.job_tag);
                r.status = (pos >= DEPTH) ? ST_FULL : ST_OK;
                r.slot = pos[4:0];
                r.run_ident = id;
            end
            ACT_DISPATCH:
                if (sched_count == 0 || sched_runs[0] == 0)
                    r.status = ST_NONE_DUE;
                else
                begin
                    per = sched_period[0];
                    r.ran = 1'b1;
                    r.run_tag = sched_tag[0];
                    r.run_ident = sched_ident[0];
                    drop_slot(0);
                    if (per > 0)
                        void'(place_task(per, per, r.run_ident, r.run_tag));
                end
            ACT_DELETE:
            begin
                pos = -1;
                for (int i = 0; i < sched_count; i++)
                    if (pos < 0 && sched_ident[i] == it.task_ident)
                        pos = i;
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.run_ident = it.task_ident;
                    drop_slot(pos);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Random idling, with quiet stretches where the gap is always zero.
    bit quiet_phase;

    // Valid stays high after a beat so that back-to-back items need no extra edge.
    task automatic send_item(item_t it);
        int gap;
        gap = quiet_phase ? 0 : short_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_results.push_back(predict_schedule(it));
        if (it.action == ACT_DISPATCH && expected_results[$].ran)
            dispatch_hits++;
        if (expected_results[$].status == ST_FULL)
            full_hits++;
        beats_sent++;
    endtask

    function automatic item_t make_item(logic [2:0] act, logic [31:0] delay,
                                        logic [31:0] period, logic [15:0] ident,
                                        logic [15:0] tag);
        item_t it;
        it.action = act;
        it.delay_ticks = delay;
        it.period_ticks = period;
        it.task_ident = ident;
        it.job_tag = tag;
        return it;
    endfunction

    // Receiver side: random stalls and the check of each result beat.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                beats_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, result);
                    error_count++;
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (want.status !== result.status || want.ran !== result.ran
                        || want.run_tag !== result.run_tag
                        || want.run_ident !== result.run_ident
                        || want.slot !== result.slot)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        error_count++;
                    end
                end
            end
            result_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 9) < 3);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d results pending", expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom();
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3: return $urandom();
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    task automatic test_directed();
        send_item(make_item(ACT_TICK, '0, '0, '0, '0));
        send_item(make_item(ACT_DISPATCH, '0, '0, '0, '0));
        send_item(make_item(ACT_DELETE, '0, '0, 16'hFFFF, '0));
        send_item(make_item(ACT_ADD_ID, '0, 32'd2, 16'hFFFF, 16'hFFFF));
        send_item(make_item(ACT_ADD_AUTO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 16'hA5A5));
        send_item(make_item(ACT_ADD_AUTO, 32'd3, '0, '0, 16'h5A5A));
        send_item(make_item(ACT_DISPATCH, '0, '0, '0, '0));
        send_item(make_item(ACT_TICK, '0, '0, '0, '0));
        send_item(make_item(ACT_TICK, '0, '0, '0, '0));
        send_item(make_item(ACT_DISPATCH, '0, '0, '0, '0));
        send_item(make_item(ACT_DELETE, '0, '0, 16'd1, '0));
        send_item(make_item(ACT_DELETE, '0, '0, 16'd1, '0));
        // Unused action codes are ignored.
        for (int a = 5; a < 8; a++)
            send_item(make_item(a[2:0], '1, '1, '1, '1));
        // Fill the table past its limit.
        for (int k = 0; k < DEPTH + 2; k++)
            send_item(make_item(ACT_ADD_AUTO, $urandom_range(0, 9), '0, '0, k[15:0]));
        send_item(make_item(ACT_ADD_ID, 32'd1, 32'd1, 16'h1234, 16'h4321));
    endtask

    task automatic clear_table();
        while (sched_count > 0)
            send_item(make_item(ACT_DELETE, '0, '0, sched_ident[0], '0));
    endtask

    // Run count saturation: a due head ticked more than 255 times.
    task automatic test_run_saturation();
        send_item(make_item(ACT_ADD_ID, '0, '0, 16'h00AA, 16'h00BB));
        for (int k = 0; k < 260; k++)
            send_item(make_item(ACT_TICK, '0, '0, '0, '0));
        send_item(make_item(ACT_DISPATCH, '0, '0, '0, '0));
        send_item(make_item(ACT_DISPATCH, '0, '0, '0, '0));
    endtask

    // Mostly realistic traffic: adds, ticks, dispatches and deletes with random content.
    task automatic test_random_traffic(int count);
        item_t it;
        int    roll;
        for (int n = 0; n < count; n++)
        begin
            if (n % 200 == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            it = make_item(ACT_TICK, $urandom(), $urandom(), 16'($urandom()),
                           16'($urandom()));
            if (roll < 15)
            begin
                it.action = ACT_ADD_AUTO;
                it.delay_ticks = pick_delay();
                it.period_ticks = pick_period();
            end
            else if (roll < 25)
            begin
                it.action = ACT_ADD_ID;
                it.delay_ticks = pick_delay();
                it.period_ticks = pick_period();
                if ($urandom_range(0, 1))
                    it.task_ident = 16'($urandom_range(0, 7));
            end
            else if (roll < 55)
                it.action = ACT_TICK;
            else if (roll < 80)
                it.action = ACT_DISPATCH;
            else if (roll < 95)
            begin
                it.action = ACT_DELETE;
                if (sched_count > 0 && $urandom_range(0, 2) != 0)
                    it.task_ident = sched_ident[$urandom_range(0, sched_count - 1)];
            end
            else
                it.action = 3'($urandom_range(5, 7));
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        dispatch_hits = 0;
        full_hits = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        sched_count = 0;
        next_auto_ident = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sched_delta[i] = '0;
            sched_period[i] = '0;
            sched_runs[i] = '0;
            sched_ident[i] = '0;
            sched_tag[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        clear_table();
        test_run_saturation();
        clear_table();
        test_random_traffic(900);
        item_valid <= 1'b0;

        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Sent %0d items and checked %0d result beats.", beats_sent, beats_checked);
        $display("Saw %0d released tasks and %0d refused adds.", dispatch_hits, full_hits);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ delta_list_task_scheduler.f @@
design/dlts_pkg.sv
design/dlts_ram.sv
design/dlts_engine.sv
design/delta_list_task_scheduler.sv
tb/delta_list_task_scheduler_test.sv
